[hw/rtl/fifo_fair_lock_arbiter_top_assert.svh]
// Assertion macros for the FIFO-fair lock arbiter.
// No dependencies; included by the top level only.
`ifndef FIFO_FAIR_LOCK_ARBITER_TOP_ASSERT_SVH
`define FIFO_FAIR_LOCK_ARBITER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define FFLA_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FFLA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

// condition must never hold
`define FFLA_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error(msg);

`else

`define FFLA_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define FFLA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`define FFLA_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

[hw/rtl/ffla_pkg.sv]
// Shared types, codes and defaults for the FIFO-fair lock arbiter.
// No dependencies; used by ffla_queue and fifo_fair_lock_arbiter_top.
`default_nettype none

package ffla_pkg;

	localparam int NUM_CPUS_DEF  = 4;
	localparam int NUM_LOCKS_DEF = 8;

	// command codes
	localparam logic [1:0] CMD_LOCK   = 2'd0;
	localparam logic [1:0] CMD_TRY    = 2'd1;
	localparam logic [1:0] CMD_UNLOCK = 2'd2;
	localparam logic [1:0] CMD_BAD    = 2'd3;

	typedef enum logic [2:0] {
		ST_GRANTED   = 3'd0,
		ST_QUEUED    = 3'd1,
		ST_TRY_FAIL  = 3'd2,
		ST_RELEASED  = 3'd3,
		ST_DOUBLE    = 3'd4,
		ST_ALREADY_Q = 3'd5,
		ST_NOT_HEAD  = 3'd6,
		ST_NOT_OWNER = 3'd7
	} status_t;

	typedef logic [1:0] cpu_t;
	typedef logic [2:0] lock_t;

	typedef struct packed {
		logic [1:0] cmd;
		cpu_t       cpu;
		lock_t      lock_id;
	} req_t;

	typedef struct packed {
		status_t status;
		cpu_t    target_cpu;
		lock_t   target_lock;
		logic    last;
	} res_t;

	// one wait queue slot: CPU and the lock it waits for
	typedef struct packed {
		cpu_t  cpu;
		lock_t lock_id;
	} q_entry_t;

	typedef struct packed {
		logic push;
		logic pop;
	} q_ctrl_t;

	typedef struct packed {
		logic     empty;
		logic     single;
		q_entry_t head;
		q_entry_t next;
	} q_status_t;

endpackage

`default_nettype wire

[hw/rtl/ffla_queue.sv]
// Shift-register wait queue of {cpu, lock} slots for the lock arbiter.
// Depends on ffla_pkg.
`default_nettype none

module ffla_queue #(
	parameter int NUM_CPUS = ffla_pkg::NUM_CPUS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire ffla_pkg::q_ctrl_t   ctrl,
	input  wire ffla_pkg::q_entry_t  push_entry,
	output ffla_pkg::q_status_t      status
);

	localparam int CNTW = $clog2(NUM_CPUS + 1);

	ffla_pkg::q_entry_t ent_q [NUM_CPUS];
	logic [CNTW-1:0]    cnt_q;

	// slot 0 is the head; pop shifts everything down by one
	always_ff @(posedge clk) begin
		for (int i = 0; i < NUM_CPUS; i++) begin
			if (ctrl.pop) begin
				if (i < NUM_CPUS - 1) begin
					ent_q[i] <= ent_q[i+1];
				end
			end else if (ctrl.push && cnt_q == CNTW'(i)) begin
				ent_q[i] <= push_entry;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctrl.pop && cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end else if (ctrl.push && cnt_q != CNTW'(NUM_CPUS)) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	assign status.empty  = (cnt_q == '0);
	assign status.single = (cnt_q == CNTW'(1));
	assign status.head   = ent_q[0];
	assign status.next   = ent_q[1];

endmodule

`default_nettype wire

[hw/rtl/fifo_fair_lock_arbiter_top.sv]
// FIFO-fair lock arbiter: top level with command register, decision logic,
// lock ownership table and result registers. Depends on ffla_pkg, ffla_queue
// and fifo_fair_lock_arbiter_top_assert.svh.
//
// Channel    Ports                        Transaction
// ---------  ---------------------------  --------------------------------------
// command    start, busy, request         start && !busy at a rising edge
// result     result_strobe, result        result_strobe high for one cycle
//
// A command is registered on acceptance, decided once no promotion result is
// pending, and its first result leaves via the result register. Sustained rate
// is one command per cycle while busy is low; an unlock that also promotes the
// next waiter emits two results and holds busy high for one cycle while the
// second result drains through the output register.
// Reset leaves all locks free and the queue empty; no clearing pass.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none

module fifo_fair_lock_arbiter_top #(
	parameter int NUM_CPUS  = ffla_pkg::NUM_CPUS_DEF,
	parameter int NUM_LOCKS = ffla_pkg::NUM_LOCKS_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	output logic                 busy,
	input  wire ffla_pkg::req_t  request,
	output logic                 result_strobe,
	output ffla_pkg::res_t       result
);

	`include "fifo_fair_lock_arbiter_top_assert.svh"

	localparam int CIW = $clog2(NUM_CPUS);
	localparam int LIW = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;

	// ---------------------------------------------------------------------
	// Command register (stage 1)
	// ---------------------------------------------------------------------
	logic                accept;
	logic                advance;
	logic                req_vld_s1;
	ffla_pkg::req_t      req_s1;
	ffla_pkg::cpu_t      own_rd_s1;     // owner of req_s1.lock_id, read at accept

	// ---------------------------------------------------------------------
	// State
	// ---------------------------------------------------------------------
	logic [NUM_LOCKS-1:0] own_vld_q;    // lock held
	ffla_pkg::cpu_t       owner_mem [NUM_LOCKS];
	logic [NUM_CPUS-1:0]  queued_q;     // CPU sits in the wait queue

	ffla_pkg::q_ctrl_t    q_ctrl;
	ffla_pkg::q_entry_t   q_push;
	ffla_pkg::q_status_t  q_st;

	// result register plus one slot for a promotion grant
	logic                res_vld_q;
	ffla_pkg::res_t      res_q;
	logic                pend_vld_q;
	ffla_pkg::res_t      pend_q;

	// decision outputs
	logic                r0_fire;
	logic                r1_fire;
	ffla_pkg::res_t      r0;
	ffla_pkg::res_t      r1;
	logic                vset_en;
	logic [LIW-1:0]      vset_idx;
	logic                vclr_en;
	logic [LIW-1:0]      vclr_idx;
	logic                own_we;
	logic [LIW-1:0]      own_waddr;
	ffla_pkg::cpu_t      own_wdata;
	logic                qset_en;
	logic                qclr_en;

	logic [LIW-1:0]      in_lidx;

	// A promotion result must drain before the next command is decided.
	assign busy    = pend_vld_q;
	assign accept  = start && !busy;
	assign advance = req_vld_s1 && !pend_vld_q;
	assign in_lidx = LIW'(request.lock_id);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_vld_s1 <= 1'b0;
		end else if (accept) begin
			req_vld_s1 <= 1'b1;
		end else if (advance) begin
			req_vld_s1 <= 1'b0;
		end
	end

	// Owner table read at accept, with bypass of the write made at the same edge.
	always_ff @(posedge clk) begin
		if (own_we) begin
			owner_mem[own_waddr] <= own_wdata;
		end
		if (accept) begin
			req_s1 <= request;
			if (own_we && own_waddr == in_lidx) begin
				own_rd_s1 <= own_wdata;
			end else begin
				own_rd_s1 <= owner_mem[in_lidx];
			end
		end
	end

	ffla_queue #(
		.NUM_CPUS (NUM_CPUS)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (q_ctrl),
		.push_entry (q_push),
		.status     (q_st)
	);

	// ---------------------------------------------------------------------
	// Decision logic for the command in stage 1
	// ---------------------------------------------------------------------
	always_comb begin
		logic           in_range;
		logic [LIW-1:0] lidx;
		logic [LIW-1:0] pidx;
		logic [CIW-1:0] cidx;
		logic           l_owned;
		logic           l_mine;
		logic           is_head;
		logic           p_free;

		in_range = (req_s1.cmd != ffla_pkg::CMD_BAD)
		        && (32'(req_s1.cpu) < NUM_CPUS)
		        && (32'(req_s1.lock_id) < NUM_LOCKS);
		lidx     = LIW'(req_s1.lock_id);
		cidx     = CIW'(req_s1.cpu);
		pidx     = LIW'(q_st.next.lock_id);
		l_owned  = own_vld_q[lidx];
		l_mine   = l_owned && (own_rd_s1 == req_s1.cpu);
		is_head  = !q_st.empty && (q_st.head.cpu == req_s1.cpu);
		p_free   = 1'b0;

		r0_fire   = 1'b0;
		r1_fire   = 1'b0;
		r0        = '{status: ffla_pkg::ST_GRANTED, target_cpu: req_s1.cpu,
		              target_lock: req_s1.lock_id, last: 1'b1};
		r1        = '{status: ffla_pkg::ST_GRANTED, target_cpu: q_st.next.cpu,
		              target_lock: q_st.next.lock_id, last: 1'b1};
		vset_en   = 1'b0;
		vset_idx  = lidx;
		vclr_en   = 1'b0;
		vclr_idx  = lidx;
		own_we    = 1'b0;
		own_waddr = lidx;
		own_wdata = req_s1.cpu;
		qset_en   = 1'b0;
		qclr_en   = 1'b0;
		q_ctrl    = '{push: 1'b0, pop: 1'b0};
		q_push    = '{cpu: req_s1.cpu, lock_id: req_s1.lock_id};

		if (advance && in_range) begin
			r0_fire = 1'b1;
			if (req_s1.cmd != ffla_pkg::CMD_UNLOCK) begin
				priority if (l_mine) begin
					r0.status = ffla_pkg::ST_DOUBLE;
				end else if (queued_q[cidx]) begin
					r0.status = ffla_pkg::ST_ALREADY_Q;
				end else if (req_s1.cmd == ffla_pkg::CMD_TRY) begin
					if (q_st.empty && !l_owned) begin
						q_ctrl.push = 1'b1;
						qset_en     = 1'b1;
						vset_en     = 1'b1;
						own_we      = 1'b1;
						r0.status   = ffla_pkg::ST_GRANTED;
					end else begin
						r0.status   = ffla_pkg::ST_TRY_FAIL;
					end
				end else begin
					q_ctrl.push = 1'b1;
					qset_en     = 1'b1;
					if (q_st.empty && !l_owned) begin
						vset_en   = 1'b1;
						own_we    = 1'b1;
						r0.status = ffla_pkg::ST_GRANTED;
					end else begin
						r0.status = ffla_pkg::ST_QUEUED;
					end
				end
			end else if (!is_head) begin
				r0.status = ffla_pkg::ST_NOT_HEAD;
			end else begin
				// head leaves the queue whether or not it owns the lock
				q_ctrl.pop = 1'b1;
				qclr_en    = 1'b1;
				if (l_mine) begin
					vclr_en   = 1'b1;
					r0.status = ffla_pkg::ST_RELEASED;
				end else begin
					r0.status = ffla_pkg::ST_NOT_OWNER;
				end
				// promote the new head if its lock is free after this release
				p_free = !own_vld_q[pidx] || (l_mine && pidx == lidx);
				if (!q_st.single && p_free) begin
					r1_fire   = 1'b1;
					r0.last   = 1'b0;
					vset_en   = 1'b1;
					vset_idx  = pidx;
					own_we    = 1'b1;
					own_waddr = pidx;
					own_wdata = q_st.next.cpu;
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Lock valid bits and queued flags
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_vld_q <= '0;
			queued_q  <= '0;
		end else begin
			for (int i = 0; i < NUM_LOCKS; i++) begin
				// a grant of the lock just released wins
				if (vset_en && vset_idx == LIW'(i)) begin
					own_vld_q[i] <= 1'b1;
				end else if (vclr_en && vclr_idx == LIW'(i)) begin
					own_vld_q[i] <= 1'b0;
				end
			end
			for (int i = 0; i < NUM_CPUS; i++) begin
				if (qset_en && CIW'(req_s1.cpu) == CIW'(i)) begin
					queued_q[i] <= 1'b1;
				end else if (qclr_en && CIW'(req_s1.cpu) == CIW'(i)) begin
					queued_q[i] <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Result registers
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q  <= 1'b0;
			pend_vld_q <= 1'b0;
		end else if (pend_vld_q) begin
			res_vld_q  <= 1'b1;
			pend_vld_q <= 1'b0;
		end else begin
			res_vld_q  <= r0_fire;
			pend_vld_q <= r1_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (pend_vld_q) begin
			res_q <= pend_q;
		end else if (r0_fire) begin
			res_q  <= r0;
			pend_q <= r1;
		end
	end

	assign result_strobe = res_vld_q;
	assign result        = res_q;

	// ---------------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------------
	`FFLA_ASSERT_NEXT(a_promo_follows, clk, arst_n, pend_vld_q, result_strobe && result.last && result.status == ffla_pkg::ST_GRANTED, "promotion grant not delivered")
	`FFLA_ASSERT_NEXT(a_last_closes, clk, arst_n, result_strobe && !result.last, result_strobe, "result sequence cut short")
	`FFLA_ASSERT_NEVER(a_queue_flags, clk, arst_n, q_st.empty != (queued_q == '0), "queue occupancy and queued flags disagree")

endmodule

`default_nettype wire
